// ===== src/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// Shared widths, constants and item types for the segment intersection
// scale pipeline.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int DIFF_W      = PROD_W + 1;
  localparam int MAG_W       = DIFF_W;
  localparam int SCALE_W     = FRAC_BITS + 1;

  localparam logic [SCALE_W-1:0] SCALE_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SCALE_W-1:0] SCALE_ZERO = '0;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] seg_x;
    logic signed [COORD_WIDTH-1:0] seg_y;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
  } query_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic               parallel_error;
  } result_t;

  // one item inside the divider pipeline
  typedef struct packed {
    logic [MAG_W-1:0]     rem;
    logic [MAG_W-1:0]     dvs;
    logic [FRAC_BITS-1:0] quo;
    logic                 bypass;
    logic                 fix_one;
    logic                 par_err;
  } div_item_t;

endpackage

// ===== src/segment_intersection_scale.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_scale
// Fraction along a 2D segment where a ray meets it, clamped to [0,1].
// ----------------------------------------------------------------------------
// Query channel (query_valid/query_ready/query): segment vector, ray point
// and ray direction, signed fixed point in one shared format.
// Result channel (result_valid/result_ready/result): scale in unsigned
// Q1.FRAC_BITS (1 << FRAC_BITS is 1.0) and parallel_error, set with
// scale = 1.0 when the denominator cross product is zero.
// Pipeline stages: one for the four products, one for the two cross
// products, one for sign classification, FRAC_BITS stages of the
// restoring divider (one quotient bit each) and the output register.
// Throughput is one item per cycle while the receiver is ready; each
// stage has its own valid bit and takes a new item whenever it is empty
// or its successor moves, so bubbles close up while the receiver stalls
// and nothing is dropped or repeated.
// Synchronous reset empties the pipeline; items in flight are discarded.
// ----------------------------------------------------------------------------
module segment_intersection_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             query_valid,
  output logic             query_ready,
  input  sis_pkg::query_t  query,
  output logic             result_valid,
  input  logic             result_ready,
  output sis_pkg::result_t result
);
  import sis_pkg::*;

  logic      front_valid, front_ready;
  div_item_t front_item;
  logic      div_valid, div_ready;
  div_item_t div_item;
  result_t   result_next;

  sis_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query_valid),
    .in_ready  (query_ready),
    .in_item   (query),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_item  (front_item)
  );

  sis_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_item  (div_item)
  );

  assign div_ready = ~result_valid | result_ready;

  always_comb begin
    if (div_item.bypass) begin
      result_next.scale = div_item.fix_one ? SCALE_ONE : SCALE_ZERO;
    end else begin
      result_next.scale = {1'b0, div_item.quo};
    end
    result_next.parallel_error = div_item.par_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (div_ready) begin
      result_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      result <= result_next;
    end
  end

  // parallel lines always report full scale
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.parallel_error |-> result.scale == SCALE_ONE)
    else $error("parallel item without full scale");

  // clamped fraction never exceeds one
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.scale <= SCALE_ONE)
    else $error("scale above one");

  // a divided item never sets the error flag
  assert property (@(posedge clk) disable iff (rst)
    div_valid && !div_item.bypass |-> !div_item.par_err)
    else $error("error flag on divided item");

  // reset empties the output stage
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

// ===== src/sis_front.sv =====
// ----------------------------------------------------------------------------
// sis_front
// Three register stages: cross-product terms, numerator and denominator,
// then sign classification and magnitudes for the divider.
// ----------------------------------------------------------------------------
module sis_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sis_pkg::query_t    in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sis_pkg::div_item_t out_item
);
  import sis_pkg::*;

  logic [2:0] vld;
  logic [2:0] rdy;

  // stage 1: products
  logic signed [PROD_W-1:0] p_vy;
  logic signed [PROD_W-1:0] v_py;
  logic signed [PROD_W-1:0] s_vy;
  logic signed [PROD_W-1:0] v_sy;
  // stage 2: cross products
  logic signed [DIFF_W-1:0] num;
  logic signed [DIFF_W-1:0] den;
  // stage 3
  div_item_t                cls;

  logic signed [COORD_WIDTH-1:0] sx, sy, px, py, vx, vy;
  logic signed [PROD_W-1:0]      p_vy_next, v_py_next, s_vy_next, v_sy_next;
  logic                          den_zero, den_pos, den_neg, res_one, res_zero;
  logic [MAG_W-1:0]              num_mag, den_mag;
  div_item_t                     cls_next;

  assign rdy[2]    = ~vld[2] | out_ready;
  assign rdy[1]    = ~vld[1] | rdy[2];
  assign rdy[0]    = ~vld[0] | rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld[2];
  assign out_item  = cls;

  always_comb begin
    sx = in_item.seg_x;
    sy = in_item.seg_y;
    px = in_item.point_x;
    py = in_item.point_y;
    vx = in_item.dir_x;
    vy = in_item.dir_y;
    p_vy_next = PROD_W'(px) * PROD_W'(vy);
    v_py_next = PROD_W'(vx) * PROD_W'(py);
    s_vy_next = PROD_W'(sx) * PROD_W'(vy);
    v_sy_next = PROD_W'(vx) * PROD_W'(sy);
  end

  always_comb begin
    den_zero = (den == '0);
    den_neg  = den[DIFF_W-1];
    den_pos  = ~den_neg & ~den_zero;
    res_one  = (den_pos & (num >= den)) | (den_neg & (num <= den)) | den_zero;
    res_zero = (den_pos & num[DIFF_W-1]) | (den_neg & ~num[DIFF_W-1] & (num != '0));
    num_mag  = num[DIFF_W-1] ? MAG_W'(-num) : MAG_W'(num);
    den_mag  = den[DIFF_W-1] ? MAG_W'(-den) : MAG_W'(den);
    cls_next.rem     = num_mag;
    cls_next.dvs     = den_mag;
    cls_next.quo     = '0;
    cls_next.bypass  = res_one | res_zero;
    cls_next.fix_one = res_one;
    cls_next.par_err = den_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p_vy <= p_vy_next;
      v_py <= v_py_next;
      s_vy <= s_vy_next;
      v_sy <= v_sy_next;
    end
    if (rdy[1]) begin
      num <= {p_vy[PROD_W-1], p_vy} - {v_py[PROD_W-1], v_py};
      den <= {s_vy[PROD_W-1], s_vy} - {v_sy[PROD_W-1], v_sy};
    end
    if (rdy[2]) begin
      cls <= cls_next;
    end
  end

endmodule

// ===== src/sis_div.sv =====
// ----------------------------------------------------------------------------
// sis_div
// Pipelined restoring divider, one quotient bit per register stage,
// FRAC_BITS stages; bypass items pass through the same stages and keep their flags.
// ----------------------------------------------------------------------------
module sis_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sis_pkg::div_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sis_pkg::div_item_t out_item
);
  import sis_pkg::*;

  logic [FRAC_BITS-1:0] vld;
  logic [FRAC_BITS-1:0] rdy;
  logic [FRAC_BITS-1:0] vld_src;
  div_item_t            stg [FRAC_BITS];

  assign in_ready  = rdy[0];
  assign out_valid = vld[FRAC_BITS-1];
  assign out_item  = stg[FRAC_BITS-1];

  genvar k;
  generate
    for (k = 0; k < FRAC_BITS; k++) begin : g_stage
      div_item_t      src;
      div_item_t      nxt;
      logic [MAG_W:0] shifted;
      logic [MAG_W:0] diff;
      logic           fits;

      if (k == 0) begin : g_first
        assign src        = in_item;
        assign vld_src[k] = in_valid;
      end else begin : g_rest
        assign src        = stg[k-1];
        assign vld_src[k] = vld[k-1];
      end

      if (k == FRAC_BITS - 1) begin : g_last_rdy
        assign rdy[k] = ~vld[k] | out_ready;
      end else begin : g_mid_rdy
        assign rdy[k] = ~vld[k] | rdy[k+1];
      end

      always_comb begin
        shifted     = {src.rem, 1'b0};
        diff        = shifted - {1'b0, src.dvs};
        fits        = (shifted >= {1'b0, src.dvs});
        nxt         = src;
        nxt.rem     = fits ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
        nxt.quo     = {src.quo[FRAC_BITS-2:0], fits};
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= vld_src[k];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          stg[k] <= nxt;
        end
      end
    end
  endgenerate

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_intersection_scale. Queries go in through
// a valid/ready sender task; a local predictor forms both cross products at
// full width, clamps the ratio and runs its own restoring division to get the
// expected scale and parallel flag. Results are checked in order against the
// queue of predicted scales while both sides idle at random, stream with no
// idling, and run against a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import sis_pkg::*;

  localparam int STALL_PCT    = 25;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCHDOG_MAX = 3000;
  localparam int DRAIN_CYCLES = FRAC_BITS + 12;

  logic    clk = 1'b0;
  logic    rst;
  logic    query_valid;
  logic    query_ready;
  query_t  query;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  result_t predicted_scales[$];
  int      error_count = 0;
  int      stuck_cycles = 0;
  int      hold_left = 0;
  bit      tx_gaps = 1'b1;
  logic    rx_stalls;
  logic    rx_hold_req;

  segment_intersection_scale u_top (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_ready  (query_ready),
    .query        (query),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // expected scale for one query: clamp the ratio num/den to [0,1] in Q1.FRAC_BITS
  function automatic result_t predict_scale(query_t q);
    longint          num;
    longint          den;
    longint unsigned rem;
    longint unsigned dvs;
    longint unsigned quo;
    result_t         r;
    num = longint'($signed(q.point_x)) * longint'($signed(q.dir_y))
        - longint'($signed(q.dir_x)) * longint'($signed(q.point_y));
    den = longint'($signed(q.seg_x)) * longint'($signed(q.dir_y))
        - longint'($signed(q.dir_x)) * longint'($signed(q.seg_y));
    r.scale          = SCALE_ONE;
    r.parallel_error = 1'b0;
    if (den == 0) begin
      r.parallel_error = 1'b1;
    end else if ((den > 0 && num >= den) || (den < 0 && num <= den)) begin
      r.scale = SCALE_ONE;
    end else if ((den > 0 && num < 0) || (den < 0 && num > 0)) begin
      r.scale = SCALE_ZERO;
    end else begin
      rem = (num < 0) ? -num : num;
      dvs = (den < 0) ? -den : den;
      quo = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= dvs) begin
          rem = rem - dvs;
          quo = quo | 1;
        end
      end
      r.scale = quo[SCALE_W-1:0];
    end
    return r;
  endfunction

  // ray along +y gives num = point_x, den = seg_x; ray along -x gives
  // num = point_y, den = seg_y; the other coordinates are don't-care
  function automatic query_t ratio_query(int n, int d);
    query_t q;
    q = query_t'({$urandom, $urandom, $urandom});
    if ($urandom_range(1)) begin
      q.seg_x   = d[COORD_WIDTH-1:0];
      q.point_x = n[COORD_WIDTH-1:0];
      q.dir_x   = '0;
      q.dir_y   = COORD_WIDTH'(1);
    end else begin
      q.seg_y   = d[COORD_WIDTH-1:0];
      q.point_y = n[COORD_WIDTH-1:0];
      q.dir_x   = '1;
      q.dir_y   = '0;
    end
    return q;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] small_coord();
    return COORD_WIDTH'($urandom_range(16) - 8);
  endfunction

  function automatic query_t random_query();
    query_t q;
    int     d;
    int     m;
    q = query_t'({$urandom, $urandom, $urandom});
    case ($urandom_range(9))
      4, 5: begin
        q.seg_x   = small_coord();
        q.seg_y   = small_coord();
        q.point_x = small_coord();
        q.point_y = small_coord();
        q.dir_x   = small_coord();
        q.dir_y   = small_coord();
      end
      6: begin
        // segment along the ray, reversed or empty
        case ($urandom_range(2))
          0: begin
            q.seg_x = q.dir_x;
            q.seg_y = q.dir_y;
          end
          1: begin
            q.seg_x = -q.dir_x;
            q.seg_y = -q.dir_y;
          end
          default: begin
            q.seg_x = '0;
            q.seg_y = '0;
          end
        endcase
      end
      7, 8: begin
        // ratio inside [0,1]
        if ($urandom_range(1)) d = $urandom_range(20, 1);
        else d = $urandom_range(32767, 1);
        m = $urandom_range(d);
        if ($urandom_range(1)) begin
          d = -d;
          m = -m;
        end
        q = ratio_query(m, d);
      end
      9: begin
        // right at the clamp to one
        d = $urandom_range(32766, 1);
        m = d + $urandom_range(2) - 1;
        if ($urandom_range(1)) begin
          d = -d;
          m = -m;
        end
        q = ratio_query(m, d);
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic send_query(input query_t q);
    int gap;
    gap = 0;
    while (tx_gaps && $urandom_range(99) < STALL_PCT) gap++;
    if (gap > 0) begin
      query_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_valid <= 1'b1;
    query       <= q;
    @(posedge clk);
    while (!query_ready) @(posedge clk);
    predicted_scales.push_back(predict_scale(q));
  endtask

  task automatic test_directed();
    query_t q;
    send_query(ratio_query(0, 0));            // parallel with zero numerator
    send_query(ratio_query(5, 0));            // parallel with nonzero numerator
    send_query(ratio_query(7, 7));            // ratio exactly one
    send_query(ratio_query(100, 7));          // ratio above one
    send_query(ratio_query(-7, -7));          // exactly one, negative den
    send_query(ratio_query(-100, -7));
    send_query(ratio_query(-3, 10));          // negative ratio
    send_query(ratio_query(3, -10));
    send_query(ratio_query(3, 10));           // fraction
    send_query(ratio_query(-3, -10));
    send_query(ratio_query(0, 10));           // zero numerator
    send_query(ratio_query(0, -10));
    send_query(ratio_query(32766, 32767));    // just under one, truncated
    send_query(ratio_query(1, 32767));
    send_query(ratio_query(-1, -32768));
    send_query(ratio_query(32767, -32768));
    send_query(ratio_query(-32768, -32768));
    send_query(ratio_query(-32768, 32767));
    send_query(ratio_query(32767, 32767));
    q = '0;
    send_query(q);
    q = {6{16'h7fff}};
    send_query(q);
    q = {6{16'h8000}};
    send_query(q);
    q = '1;
    send_query(q);
    q = {16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff};
    send_query(q);
  endtask

  task automatic test_random_mix(input int count);
    tx_gaps   = 1'b1;
    rx_stalls <= 1'b1;
    repeat (count) send_query(random_query());
  endtask

  task automatic test_streaming(input int count);
    tx_gaps   = 1'b0;
    rx_stalls <= 1'b0;
    repeat (count) send_query(random_query());
  endtask

  // receiver holds off while the sender keeps offering, so the pipe fills
  task automatic test_backpressure(input int count);
    tx_gaps     = 1'b0;
    rx_stalls   <= 1'b1;
    rx_hold_req <= 1'b1;
    repeat (count) send_query(random_query());
    tx_gaps = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req <= 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= !(rx_stalls && $urandom_range(99) < STALL_PCT);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (predicted_scales.size() == 0) begin
        $display("%0t: result with no query pending: scale=%h parallel_error=%b",
                 $time, result.scale, result.parallel_error);
        error_count++;
      end else begin
        want = predicted_scales.pop_front();
        if (result.scale !== want.scale) begin
          $display("%0t: scale mismatch: expected %h actual %h",
                   $time, want.scale, result.scale);
          error_count++;
        end
        if (result.parallel_error !== want.parallel_error) begin
          $display("%0t: parallel_error mismatch: expected %b actual %b",
                   $time, want.parallel_error, result.parallel_error);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((query_valid && query_ready) || (result_valid && result_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_MAX);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst          <= 1'b1;
    query_valid  <= 1'b0;
    query        <= '0;
    result_ready <= 1'b0;
    rx_stalls    <= 1'b1;
    rx_hold_req  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(300);
    test_streaming(150);
    test_backpressure(125);
    test_random_mix(150);

    query_valid <= 1'b0;
    while (predicted_scales.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && predicted_scales.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
